// ===== src/conv3_pkg.sv =====
// Shared types, widths, register indexes and kernel constants for the 3x3 convolution filter.
`timescale 1ns / 1ps
`default_nettype none

package conv3_pkg;

   localparam int PixW             = 8;
   localparam int CoordW           = 10;
   localparam int DimW             = 11;
   localparam int CsrIndexW        = 2;
   localparam int MaxWidthDefault  = 1024;
   localparam int MaxHeightDefault = 1024;
   localparam logic [DimW-1:0] DimReset = DimW'(1024);

   localparam int RecipShift = 28;
   localparam int MulW       = 27;
   localparam logic [MulW-1:0] BoxMul  =
      MulW'(((64'd11111 << RecipShift) + 64'd99999) / 64'd100000);
   localparam logic [MulW-1:0] Div3Mul =
      MulW'(((64'd1 << RecipShift) + 64'd2) / 64'd3);

   typedef logic [PixW-1:0] pixel_type;
   typedef pixel_type [2:0] column_type;
   typedef pixel_type [2:0][2:0] window_type;

   typedef enum logic [2:0] {
      KM_BOX       = 3'd0,
      KM_GAUSS     = 3'd1,
      KM_PREWITT_X = 3'd2,
      KM_PREWITT_Y = 3'd3,
      KM_SOBEL_X   = 3'd4,
      KM_SOBEL_Y   = 3'd5,
      KM_LAPLACE   = 3'd6,
      KM_SHARPEN   = 3'd7
   } kernel_mode_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_KERNEL_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ===== src/conv3_line_buffer.sv =====
// Two single-row line stores with a registered read port and one write port each.
`timescale 1ns / 1ps
`default_nettype none

module conv3_line_buffer #(
   parameter int MAX_WIDTH = conv3_pkg::MaxWidthDefault
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output conv3_pkg::pixel_type         rd_older,
   output conv3_pkg::pixel_type         rd_newer,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  conv3_pkg::pixel_type         wr_older,
   input  conv3_pkg::pixel_type         wr_newer
);
   import conv3_pkg::*;

   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];
   pixel_type rd_older_ff;
   pixel_type rd_newer_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         older_mem[wr_addr] <= wr_older;
         newer_mem[wr_addr] <= wr_newer;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem[rd_addr];
         rd_newer_ff <= newer_mem[rd_addr];
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;

endmodule

`default_nettype wire

// ===== src/conv3_kernel.sv =====
// Combinational 3x3 kernel evaluation for the eight filter modes.
`timescale 1ns / 1ps
`default_nettype none

module conv3_kernel (
   input  conv3_pkg::window_type      win,
   input  conv3_pkg::kernel_mode_type mode,
   output conv3_pkg::pixel_type       result
);
   import conv3_pkg::*;

   localparam int SumW = 14;

   logic signed [SumW-1:0] p [3][3];
   logic signed [SumW-1:0] all_sum;
   logic signed [SumW-1:0] s;
   logic [SumW-1:0] mag;
   logic [MulW-1:0] mul_k;
   logic [SumW+MulW-1:0] product;
   logic [SumW+MulW-1:0] quotient;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p[r][c] = SumW'(win[r][c]);
         end
      end
   end

   always_comb begin
      all_sum = p[0][0] + p[0][1] + p[0][2] + p[1][0] + p[1][1] + p[1][2]
              + p[2][0] + p[2][1] + p[2][2];
      s = all_sum;
      case (mode)
         KM_BOX: begin
            s = all_sum;
         end
         KM_GAUSS: begin
            s = p[0][0] + (p[0][1] <<< 1) + p[0][2]
              + (p[1][0] <<< 1) + (p[1][1] <<< 2) + (p[1][2] <<< 1)
              + p[2][0] + (p[2][1] <<< 1) + p[2][2];
         end
         KM_PREWITT_X: begin
            s = (p[0][2] + p[1][2] + p[2][2]) - (p[0][0] + p[1][0] + p[2][0]);
         end
         KM_PREWITT_Y: begin
            s = (p[2][0] + p[2][1] + p[2][2]) - (p[0][0] + p[0][1] + p[0][2]);
         end
         KM_SOBEL_X: begin
            s = (p[0][2] + (p[1][2] <<< 1) + p[2][2])
              - (p[0][0] + (p[1][0] <<< 1) + p[2][0]);
         end
         KM_SOBEL_Y: begin
            s = (p[2][0] + (p[2][1] <<< 1) + p[2][2])
              - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
         end
         KM_LAPLACE: begin
            s = (p[1][1] <<< 3) + p[1][1] - all_sum;
         end
         KM_SHARPEN: begin
            s = (p[1][1] <<< 3) + (p[1][1] <<< 1) - all_sum;
         end
      endcase
   end

   // The box average and the divide by three share one reciprocal multiplier.
   always_comb begin
      mag      = (s < 0) ? SumW'(-s) : SumW'(s);
      mul_k    = (mode == KM_BOX) ? BoxMul : Div3Mul;
      product  = (SumW+MulW)'(mag) * (SumW+MulW)'(mul_k);
      quotient = product >> RecipShift;
   end

   always_comb begin
      result = quotient[PixW-1:0];
      case (mode) inside
         KM_BOX, KM_PREWITT_X, KM_PREWITT_Y: begin
            result = quotient[PixW-1:0];
         end
         KM_GAUSS: begin
            result = mag[PixW+3:4];
         end
         KM_SOBEL_X, KM_SOBEL_Y: begin
            result = mag[PixW+1:2];
         end
         KM_LAPLACE: begin
            result = mag[PixW+2:3];
         end
         KM_SHARPEN: begin
            if (s < 0) begin
               result = '0;
            end else if (s > SumW'(255)) begin
               result = '1;
            end else begin
               result = s[PixW-1:0];
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/conv3x3_kernel_filter_top.sv =====
// Top level of the 3x3 convolution filter: registers, counters, window and output stage.
// A pixel is registered in stage one, then its result in the output register.
// Throughput: one pixel per cycle if not stalled, set by each line store's single ports.
// Border pixels complete a transaction but give no result transaction.
// Reset clears the counters, the pipeline valid flags and the registers to their defaults.
// Line stores and window need no clearing; no result reads an entry before it is written.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_kernel_filter_top #(
   parameter int MAX_WIDTH  = conv3_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = conv3_pkg::MaxHeightDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [conv3_pkg::PixW-1:0]       req_pixel_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [conv3_pkg::PixW-1:0]       rsp_pixel_out,
   output logic [conv3_pkg::CoordW-1:0]     rsp_out_row,
   output logic [conv3_pkg::CoordW-1:0]     rsp_out_col,
   output logic                             rsp_frame_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [conv3_pkg::CsrIndexW-1:0]  csr_index,
   input  logic [conv3_pkg::DimW-1:0]       csr_data
);
   import conv3_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   kernel_mode_type   kernel_mode_ff, kernel_mode_in;
   logic [DimW-1:0]   image_width_ff, image_width_in;
   logic [DimW-1:0]   image_height_ff, image_height_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     w_last;
   logic [RW-1:0]     h_last;

   logic              s1_valid_ff, s1_valid_in;
   pixel_type         s1_pix_ff;
   logic [CW-1:0]     s1_col_ff;
   logic [RW-1:0]     s1_row_ff;
   column_type        left_col_ff, mid_col_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   pixel_type         rsp_pix_ff;
   logic [CoordW-1:0] rsp_row_ff;
   logic [CoordW-1:0] rsp_col_ff;
   logic              rsp_last_ff;

   logic              csr_fire;
   logic              geom_write;
   logic              req_fire;
   logic              s1_fire;
   logic              produced;
   pixel_type         rd_older;
   pixel_type         rd_newer;
   window_type        win;
   pixel_type         kernel_result;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign geom_write = csr_fire &&
                       (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT);

   always_comb begin
      kernel_mode_in  = kernel_mode_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_KERNEL_MODE:  kernel_mode_in  = kernel_mode_type'(csr_data[2:0]);
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (int'(image_width_ff) < 3) begin
         w_last = CW'(2);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(image_width_ff - DimW'(1));
      end
      if (int'(image_height_ff) < 3) begin
         h_last = RW'(2);
      end else if (int'(image_height_ff) > MAX_HEIGHT) begin
         h_last = RW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RW'(image_height_ff - DimW'(1));
      end
   end

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geom_write) begin
         col_in = '0;
         row_in = '0;
      end else if (req_fire) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   assign produced = (s1_row_ff >= RW'(2)) && (s1_col_ff >= CW'(2));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = produced;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff  <= KM_BOX;
         image_width_ff  <= DimReset;
         image_height_ff <= DimReset;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         kernel_mode_ff  <= kernel_mode_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff <= req_pixel_in;
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         left_col_ff   <= mid_col_ff;
         mid_col_ff[0] <= rd_older;
         mid_col_ff[1] <= rd_newer;
         mid_col_ff[2] <= s1_pix_ff;
      end
   end

   conv3_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (col_ff),
      .rd_older (rd_older),
      .rd_newer (rd_newer),
      .wr_en    (s1_fire),
      .wr_addr  (s1_col_ff),
      .wr_older (rd_newer),
      .wr_newer (s1_pix_ff)
   );

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win[k][0] = left_col_ff[k];
         win[k][1] = mid_col_ff[k];
      end
      win[0][2] = rd_older;
      win[1][2] = rd_newer;
      win[2][2] = s1_pix_ff;
   end

   conv3_kernel u_kernel (
      .win    (win),
      .mode   (kernel_mode_ff),
      .result (kernel_result)
   );

   always_ff @(posedge clock) begin
      if (s1_fire && produced) begin
         rsp_pix_ff  <= kernel_result;
         rsp_row_ff  <= CoordW'(s1_row_ff - RW'(1));
         rsp_col_ff  <= CoordW'(s1_col_ff - CW'(1));
         rsp_last_ff <= (s1_row_ff == h_last) && (s1_col_ff == w_last);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pix_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= w_last)
      else $error("Column counter beyond the effective image width.");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff && $stable(s1_col_ff) && $stable(s1_row_ff))
      else $error("Stage one transaction dropped or changed while stalled.");

   a_border_silent: assert property (@(posedge clock) disable iff (reset)
      s1_fire && !produced |=> !rsp_valid_ff)
      else $error("Border pixel produced a result transaction.");

   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_col_ff == CoordW'(w_last - CW'(1)))
      else $error("Frame end marked away from the last interior column.");

endmodule

`default_nettype wire
